>>> design/ivfq_pkg.sv
// Shared types, codes, constants and helper functions of the vector field query block.
package ivfq_pkg;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_UNDO = 2'd1;
    localparam logic [1:0] MODE_NQ   = 2'd2;
    localparam logic [1:0] MODE_GQ   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [15:0] UNIT       = 16'd16384;
    localparam logic [49:0] ZERO_W     = 50'(64'd100000 << 32);
    localparam logic [49:0] WEIGHT_MAX = {1'b0, {49{1'b1}}};
    localparam logic [63:0] R2_LIMIT   = 64'd16777216;

    typedef struct packed {
        logic [8:0]         x;
        logic [8:0]         y;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQ, OP_D2, OP_A_CHK, OP_A_SQRT, OP_A_DIVX, OP_A_DIVY,
        OP_WRITE, OP_UNDO, OP_Q_INIT, OP_RD, OP_DIFF, OP_W_DIV, OP_ZW, OP_MUL,
        OP_ACC, OP_N_ABS, OP_N_SHIFT, OP_N_LD, OP_N_SQRT, OP_N_DIVX, OP_N_DIVY,
        OP_B_LD, OP_B_SQRT, OP_B_DIVX, OP_B_DIVY, OP_B_MUL, OP_B_FIN, OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
        logic sqrt_start;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       d2_zero;
        logic       full;
        logic       cnt_zero;
        logic       last;
        logic       mir;
        logic       div_done;
        logic       sqrt_done;
        logic       sum_zero;
        logic       norm_ok;
        logic       big_r;
        logic       out_free;
    } stat_t;

    function automatic logic signed [15:0] signed_unit(input logic [63:0] q, input logic neg);
        logic [15:0] c;
        c = (q > 64'(UNIT)) ? UNIT : q[15:0];
        return neg ? -$signed(c) : $signed(c);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

>>> design/ivfq_div.sv
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
module ivfq_div
    import ivfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [63:0] den_reg;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        ge;

    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[63]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[63:0] : rem_sh[63:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

>>> design/ivfq_sqrt.sv
// Bitwise integer square root of a 64-bit value, one result bit per cycle.
module ivfq_sqrt
    import ivfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] n_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;
    logic        ge;

    always_comb
    begin
        trial = res_reg + bit_reg;
        ge    = n_reg >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= rad;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

>>> design/ivfq_dp.sv
// Datapath: vector table, accumulators, multipliers, shared divider and square root.
module ivfq_dp
    import ivfq_pkg::*;
#(
    parameter int MAX_PAIRS  = 32,
    parameter int FIELD_SIZE = 400
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         in_mode,
    input  logic [8:0]         in_pos_x,
    input  logic [8:0]         in_pos_y,
    input  logic signed [9:0]  in_delta_x,
    input  logic signed [9:0]  in_delta_y,
    input  logic signed [15:0] in_query_x,
    input  logic signed [15:0] in_query_y,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [15:0] dir_x,
    output logic signed [15:0] dir_y,
    output logic [1:0]         status,
    output logic [5:0]         pairs_stored
);

    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic signed [13:0] HALF_S = 14'(FIELD_SIZE / 2);
    localparam logic signed [13:0] FS_S   = 14'(FIELD_SIZE);

    entry_t mem [MAX_PAIRS];
    entry_t rd_reg;

    logic [1:0]         mode_reg;
    logic [8:0]         px_reg, py_reg;
    logic signed [9:0]  dx_reg, dy_reg;
    logic signed [15:0] qx_reg, qy_reg;
    logic [1:0]         status_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      idx_reg;
    logic               mir_reg;
    logic signed [31:0] gx_reg, gy_reg;
    logic [31:0]        ma_reg, mb_reg;
    logic [63:0]        sqa_reg, sqb_reg, d2_reg;
    logic [31:0]        len_reg;
    logic [49:0]        w_reg;
    logic [63:0]        pa_reg, pb_reg;
    logic               na_reg, nb_reg;
    logic signed [63:0] sx_reg, sy_reg;
    logic [63:0]        ax_reg, ay_reg;
    logic signed [15:0] rx_reg, ry_reg, tx_reg, ty_reg;
    logic signed [31:0] pxa_reg, pxb_reg, pya_reg, pyb_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_x_reg, out_y_reg;
    logic [1:0]         out_st_reg;
    logic [5:0]         out_cnt_reg;

    logic               out_free;
    logic [63:0]        div_num, div_den, div_quo, sqrt_rad;
    logic               div_done, sqrt_done;
    logic [31:0]        sqrt_root;
    logic signed [13:0] vy;
    logic signed [31:0] ddx, ddy, ex, ey;
    logic signed [17:0] qoff_x, qoff_y;
    logic [63:0]        m_max;
    logic               norm_ok;
    logic [31:0]        b_diff;
    logic signed [15:0] b_fac, k_fac;
    logic signed [32:0] bv_x, bv_y;
    logic [32:0]        bm_x, bm_y;
    logic [15:0]        br_x, br_y;
    logic [63:0]        ta, tb;
    logic [14:0]        ua, ub;
    logic               full;

    assign out_free = !out_valid_reg || out_ready;
    assign full     = cnt_reg >= CW'(MAX_PAIRS);

    always_comb
    begin
        div_num = '0;
        div_den = 64'd1;
        case (cmd.op)
            OP_A_DIVX: begin div_num = (64'(ma_reg) << 28) + 64'(len_reg >> 1); div_den = 64'(len_reg); end
            OP_A_DIVY: begin div_num = (64'(mb_reg) << 28) + 64'(len_reg >> 1); div_den = 64'(len_reg); end
            OP_N_DIVX: begin div_num = (64'(ma_reg) << 14) + 64'(len_reg >> 1); div_den = 64'(len_reg); end
            OP_N_DIVY: begin div_num = (64'(mb_reg) << 14) + 64'(len_reg >> 1); div_den = 64'(len_reg); end
            OP_B_DIVX: begin div_num = (64'(ma_reg) << 16) + 64'(len_reg >> 1); div_den = 64'(len_reg); end
            OP_B_DIVY: begin div_num = (64'(mb_reg) << 16) + 64'(len_reg >> 1); div_den = 64'(len_reg); end
            OP_W_DIV:  begin div_num = (64'd1 << 56) + (d2_reg >> 1); div_den = d2_reg; end
            default:   begin div_num = '0; div_den = 64'd1; end
        endcase
        case (cmd.op)
            OP_A_SQRT: sqrt_rad = d2_reg << 28;
            OP_B_SQRT: sqrt_rad = d2_reg << 4;
            default:   sqrt_rad = d2_reg;
        endcase
    end

    ivfq_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    ivfq_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .rad   (sqrt_rad),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_comb
    begin
        vy     = mir_reg ? (FS_S - $signed({5'b0, rd_reg.y})) : $signed({5'b0, rd_reg.y});
        ex     = $signed({11'b0, rd_reg.x, 12'b0});
        ey     = $signed({{6{vy[13]}}, vy, 12'b0});
        ddx    = gx_reg - ex;
        ddy    = gy_reg - ey;
        qoff_x = 18'(qx_reg) + 18'sd4096;
        qoff_y = 18'(qy_reg) + 18'sd4096;
        m_max  = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        norm_ok = (m_max[63:31] == '0) && m_max[30];
        b_diff = len_reg - 32'(UNIT);
        b_fac  = (b_diff > 32'(UNIT)) ? $signed(UNIT) : $signed(b_diff[15:0]);
        k_fac  = $signed(UNIT) - b_fac;
        bv_x   = 33'(pxa_reg) + 33'(pxb_reg);
        bv_y   = 33'(pya_reg) + 33'(pyb_reg);
        bm_x   = bv_x[32] ? 33'(-bv_x) : 33'(bv_x);
        bm_y   = bv_y[32] ? 33'(-bv_y) : 33'(bv_y);
        br_x   = 16'((bm_x + 33'd8192) >> 14);
        br_y   = 16'((bm_y + 33'd8192) >> 14);
        ta     = {10'b0, pa_reg[63:10]};
        tb     = {10'b0, pb_reg[63:10]};
        ua     = rd_reg.ux[15] ? 15'(-rd_reg.ux) : 15'(rd_reg.ux);
        ub     = rd_reg.uy[15] ? 15'(-rd_reg.uy) : 15'(rd_reg.uy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            mir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((cmd.op == OP_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_WRITE:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                OP_UNDO:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                OP_Q_INIT:
                begin
                    idx_reg <= '0;
                    mir_reg <= 1'b0;
                end
                OP_ACC:
                begin
                    mir_reg <= !mir_reg;
                    if (mir_reg)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= in_mode;
            px_reg     <= in_pos_x;
            py_reg     <= in_pos_y;
            dx_reg     <= in_delta_x;
            dy_reg     <= in_delta_y;
            qx_reg     <= in_query_x;
            qy_reg     <= in_query_y;
            rx_reg     <= '0;
            ry_reg     <= '0;
            status_reg <= ST_OK;
            ma_reg     <= mag32(32'(in_delta_x));
            mb_reg     <= mag32(32'(in_delta_y));
        end
        case (cmd.op)
            OP_SQ:
            begin
                sqa_reg <= 64'(ma_reg) * 64'(ma_reg);
                sqb_reg <= 64'(mb_reg) * 64'(mb_reg);
            end
            OP_D2:
            begin
                d2_reg <= sqa_reg + sqb_reg;
            end
            OP_A_CHK:
            begin
                if (d2_reg == '0)
                begin
                    status_reg <= ST_ZERO;
                end
                else if (full)
                begin
                    status_reg <= ST_FULL;
                end
            end
            OP_A_SQRT, OP_N_SQRT, OP_B_SQRT:
            begin
                if (sqrt_done)
                begin
                    len_reg <= sqrt_root;
                end
            end
            OP_A_DIVX: if (div_done) tx_reg <= signed_unit(div_quo, dx_reg[9]);
            OP_A_DIVY: if (div_done) ty_reg <= signed_unit(div_quo, dy_reg[9]);
            OP_N_DIVX: if (div_done) rx_reg <= signed_unit(div_quo, sx_reg[63]);
            OP_N_DIVY: if (div_done) ry_reg <= signed_unit(div_quo, sy_reg[63]);
            OP_B_DIVX: if (div_done) tx_reg <= signed_unit(div_quo, !qx_reg[15]);
            OP_B_DIVY: if (div_done) ty_reg <= signed_unit(div_quo, !qy_reg[15]);
            OP_WRITE:
            begin
                mem[cnt_reg[AW-1:0]] <= '{x: px_reg, y: py_reg, ux: tx_reg, uy: ty_reg};
            end
            OP_Q_INIT:
            begin
                if (mode_reg == MODE_GQ)
                begin
                    gx_reg <= $signed({11'b0, px_reg, 12'b0});
                    gy_reg <= $signed({11'b0, py_reg, 12'b0});
                end
                else
                begin
                    gx_reg <= 32'(HALF_S) * 32'(qoff_x);
                    gy_reg <= 32'(HALF_S) * 32'(qoff_y);
                end
                sx_reg <= '0;
                sy_reg <= '0;
            end
            OP_RD:
            begin
                rd_reg <= mem[idx_reg[AW-1:0]];
            end
            OP_DIFF:
            begin
                ma_reg <= mag32(ddx);
                mb_reg <= mag32(ddy);
            end
            OP_W_DIV:
            begin
                if (div_done)
                begin
                    w_reg <= (div_quo > 64'(WEIGHT_MAX)) ? WEIGHT_MAX : div_quo[49:0];
                end
            end
            OP_ZW:
            begin
                w_reg <= ZERO_W;
            end
            OP_MUL:
            begin
                pa_reg <= 64'(ua) * 64'(w_reg);
                pb_reg <= 64'(ub) * 64'(w_reg);
                na_reg <= rd_reg.ux[15];
                nb_reg <= mir_reg ? (rd_reg.uy > 16'sd0) : rd_reg.uy[15];
            end
            OP_ACC:
            begin
                sx_reg <= sx_reg + (na_reg ? -$signed(ta) : $signed(ta));
                sy_reg <= sy_reg + (nb_reg ? -$signed(tb) : $signed(tb));
            end
            OP_N_ABS:
            begin
                ax_reg <= sx_reg[63] ? 64'(-sx_reg) : 64'(sx_reg);
                ay_reg <= sy_reg[63] ? 64'(-sy_reg) : 64'(sy_reg);
            end
            OP_N_SHIFT:
            begin
                if (m_max[63:31] != '0)
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
                else if (!m_max[30])
                begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
            end
            OP_N_LD:
            begin
                ma_reg <= ax_reg[31:0];
                mb_reg <= ay_reg[31:0];
            end
            OP_B_LD:
            begin
                ma_reg <= mag32(32'(qx_reg));
                mb_reg <= mag32(32'(qy_reg));
            end
            OP_B_MUL:
            begin
                pxa_reg <= 32'(rx_reg) * 32'(k_fac);
                pxb_reg <= 32'(tx_reg) * 32'(b_fac);
                pya_reg <= 32'(ry_reg) * 32'(k_fac);
                pyb_reg <= 32'(ty_reg) * 32'(b_fac);
            end
            OP_B_FIN:
            begin
                rx_reg <= bv_x[32] ? -$signed(br_x) : $signed(br_x);
                ry_reg <= bv_y[32] ? -$signed(br_y) : $signed(br_y);
            end
            OP_OUT:
            begin
                if (out_free)
                begin
                    out_x_reg   <= rx_reg;
                    out_y_reg   <= ry_reg;
                    out_st_reg  <= status_reg;
                    out_cnt_reg <= 6'(cnt_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.mode      = mode_reg;
        stat.d2_zero   = d2_reg == '0;
        stat.full      = full;
        stat.cnt_zero  = cnt_reg == '0;
        stat.last      = ((CW + 1)'(idx_reg) + (CW + 1)'(1)) == (CW + 1)'(cnt_reg);
        stat.mir       = mir_reg;
        stat.div_done  = div_done;
        stat.sqrt_done = sqrt_done;
        stat.sum_zero  = (ax_reg == '0) && (ay_reg == '0);
        stat.norm_ok   = norm_ok;
        stat.big_r     = d2_reg > R2_LIMIT;
        stat.out_free  = out_free;
    end

    assign out_valid    = out_valid_reg;
    assign dir_x        = out_x_reg;
    assign dir_y        = out_y_reg;
    assign status       = out_st_reg;
    assign pairs_stored = out_cnt_reg;

endmodule

>>> design/ivfq_ctrl.sv
// Controller state machine that sequences the datapath for add, undo and query words.
module ivfq_ctrl
    import ivfq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE, S_DISP,
        S_A_SQ, S_A_D2, S_A_CHK, S_A_SQRT, S_A_SQW, S_A_DX, S_A_DXW, S_A_DY, S_A_DYW,
        S_A_WR, S_UNDO,
        S_Q_INIT, S_Q_RD, S_Q_DIFF, S_Q_SQ, S_Q_D2, S_Q_SEL, S_Q_WGO, S_Q_WW, S_Q_ZW,
        S_Q_MUL, S_Q_ACC,
        S_N_ABS, S_N_SH, S_N_LD, S_N_SQ, S_N_D2, S_N_SQRT, S_N_SQW, S_N_DX, S_N_DXW,
        S_N_DY, S_N_DYW,
        S_B_ENT, S_B_LD, S_B_SQ, S_B_D2, S_B_CHK, S_B_SQRT, S_B_SQW, S_B_DX, S_B_DXW,
        S_B_DY, S_B_DYW, S_B_MUL, S_B_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_DISP;
            S_DISP:
            begin
                unique case (stat.mode)
                    MODE_ADD:  state_next = S_A_SQ;
                    MODE_UNDO: state_next = S_UNDO;
                    default:   state_next = S_Q_INIT;
                endcase
            end
            S_A_SQ:   state_next = S_A_D2;
            S_A_D2:   state_next = S_A_CHK;
            S_A_CHK:  state_next = (stat.d2_zero || stat.full) ? S_OUT : S_A_SQRT;
            S_A_SQRT: state_next = S_A_SQW;
            S_A_SQW:  if (stat.sqrt_done) state_next = S_A_DX;
            S_A_DX:   state_next = S_A_DXW;
            S_A_DXW:  if (stat.div_done) state_next = S_A_DY;
            S_A_DY:   state_next = S_A_DYW;
            S_A_DYW:  if (stat.div_done) state_next = S_A_WR;
            S_A_WR:   state_next = S_OUT;
            S_UNDO:   state_next = S_OUT;
            S_Q_INIT: state_next = stat.cnt_zero ? S_N_ABS : S_Q_RD;
            S_Q_RD:   state_next = S_Q_DIFF;
            S_Q_DIFF: state_next = S_Q_SQ;
            S_Q_SQ:   state_next = S_Q_D2;
            S_Q_D2:   state_next = S_Q_SEL;
            S_Q_SEL:  state_next = stat.d2_zero ? S_Q_ZW : S_Q_WGO;
            S_Q_WGO:  state_next = S_Q_WW;
            S_Q_WW:   if (stat.div_done) state_next = S_Q_MUL;
            S_Q_ZW:   state_next = S_Q_MUL;
            S_Q_MUL:  state_next = S_Q_ACC;
            S_Q_ACC:
            begin
                if (!stat.mir)
                begin
                    state_next = S_Q_DIFF;
                end
                else
                begin
                    state_next = stat.last ? S_N_ABS : S_Q_RD;
                end
            end
            S_N_ABS:  state_next = S_N_SH;
            S_N_SH:
            begin
                if (stat.sum_zero)
                begin
                    state_next = S_B_ENT;
                end
                else if (stat.norm_ok)
                begin
                    state_next = S_N_LD;
                end
            end
            S_N_LD:   state_next = S_N_SQ;
            S_N_SQ:   state_next = S_N_D2;
            S_N_D2:   state_next = S_N_SQRT;
            S_N_SQRT: state_next = S_N_SQW;
            S_N_SQW:  if (stat.sqrt_done) state_next = S_N_DX;
            S_N_DX:   state_next = S_N_DXW;
            S_N_DXW:  if (stat.div_done) state_next = S_N_DY;
            S_N_DY:   state_next = S_N_DYW;
            S_N_DYW:  if (stat.div_done) state_next = S_B_ENT;
            S_B_ENT:  state_next = (stat.mode == MODE_NQ) ? S_B_LD : S_OUT;
            S_B_LD:   state_next = S_B_SQ;
            S_B_SQ:   state_next = S_B_D2;
            S_B_D2:   state_next = S_B_CHK;
            S_B_CHK:  state_next = stat.big_r ? S_B_SQRT : S_OUT;
            S_B_SQRT: state_next = S_B_SQW;
            S_B_SQW:  if (stat.sqrt_done) state_next = S_B_DX;
            S_B_DX:   state_next = S_B_DXW;
            S_B_DXW:  if (stat.div_done) state_next = S_B_DY;
            S_B_DY:   state_next = S_B_DYW;
            S_B_DYW:  if (stat.div_done) state_next = S_B_MUL;
            S_B_MUL:  state_next = S_B_FIN;
            S_B_FIN:  state_next = S_OUT;
            S_OUT:    if (stat.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.div_start  = 1'b0;
        cmd.sqrt_start = 1'b0;
        unique case (state_reg)
            S_IDLE:                     cmd.op = OP_LOAD;
            S_A_SQ, S_Q_SQ, S_N_SQ, S_B_SQ: cmd.op = OP_SQ;
            S_A_D2, S_Q_D2, S_N_D2, S_B_D2: cmd.op = OP_D2;
            S_A_CHK:                    cmd.op = OP_A_CHK;
            S_A_SQRT:   begin cmd.op = OP_A_SQRT; cmd.sqrt_start = 1'b1; end
            S_A_SQW:                    cmd.op = OP_A_SQRT;
            S_A_DX:     begin cmd.op = OP_A_DIVX; cmd.div_start = 1'b1; end
            S_A_DXW:                    cmd.op = OP_A_DIVX;
            S_A_DY:     begin cmd.op = OP_A_DIVY; cmd.div_start = 1'b1; end
            S_A_DYW:                    cmd.op = OP_A_DIVY;
            S_A_WR:                     cmd.op = OP_WRITE;
            S_UNDO:                     cmd.op = OP_UNDO;
            S_Q_INIT:                   cmd.op = OP_Q_INIT;
            S_Q_RD:                     cmd.op = OP_RD;
            S_Q_DIFF:                   cmd.op = OP_DIFF;
            S_Q_WGO:    begin cmd.op = OP_W_DIV; cmd.div_start = 1'b1; end
            S_Q_WW:                     cmd.op = OP_W_DIV;
            S_Q_ZW:                     cmd.op = OP_ZW;
            S_Q_MUL:                    cmd.op = OP_MUL;
            S_Q_ACC:                    cmd.op = OP_ACC;
            S_N_ABS:                    cmd.op = OP_N_ABS;
            S_N_SH:                     cmd.op = OP_N_SHIFT;
            S_N_LD:                     cmd.op = OP_N_LD;
            S_N_SQRT:   begin cmd.op = OP_N_SQRT; cmd.sqrt_start = 1'b1; end
            S_N_SQW:                    cmd.op = OP_N_SQRT;
            S_N_DX:     begin cmd.op = OP_N_DIVX; cmd.div_start = 1'b1; end
            S_N_DXW:                    cmd.op = OP_N_DIVX;
            S_N_DY:     begin cmd.op = OP_N_DIVY; cmd.div_start = 1'b1; end
            S_N_DYW:                    cmd.op = OP_N_DIVY;
            S_B_LD:                     cmd.op = OP_B_LD;
            S_B_SQRT:   begin cmd.op = OP_B_SQRT; cmd.sqrt_start = 1'b1; end
            S_B_SQW:                    cmd.op = OP_B_SQRT;
            S_B_DX:     begin cmd.op = OP_B_DIVX; cmd.div_start = 1'b1; end
            S_B_DXW:                    cmd.op = OP_B_DIVX;
            S_B_DY:     begin cmd.op = OP_B_DIVY; cmd.div_start = 1'b1; end
            S_B_DYW:                    cmd.op = OP_B_DIVY;
            S_B_MUL:                    cmd.op = OP_B_MUL;
            S_B_FIN:                    cmd.op = OP_B_FIN;
            S_OUT:                      cmd.op = OP_OUT;
            default:                    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

>>> design/idw_vector_field_query_top.sv
// Top level of the inverse-distance-weighted vector field query block.
//
// One word is taken at a time and each gives exactly one result word. An add runs
// one square root and two divisions before it writes its entry; a rejected add and
// an undo need neither. A query runs one weight division in the shared divider for
// every entry and its mirror whose distance is not zero, and the final normalization,
// skipped when both sums are zero, shifts the sums into range and adds a square root
// and two divisions; a normalized query then checks its radius, and one outside the
// unit circle is blended after a further square root and two divisions.
// A finished result waits in the output register while the next word is accepted.
module idw_vector_field_query_top
    import ivfq_pkg::*;
#(
    parameter int MAX_PAIRS  = 32,
    parameter int FIELD_SIZE = 400
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // pos_x, pos_y, delta_x, delta_y, query_x, query_y, zero pad
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // dir_x, dir_y, status, pairs_stored
);

    cmd_t               cmd;
    stat_t              stat;
    logic               accept;
    logic signed [15:0] dir_x, dir_y;
    logic [1:0]         status;
    logic [5:0]         pairs_stored;

    assign accept = s_tvalid && s_tready;

    ivfq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ivfq_dp #(
        .MAX_PAIRS  (MAX_PAIRS),
        .FIELD_SIZE (FIELD_SIZE)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_mode      (s_tuser),
        .in_pos_x     (s_tdata[8:0]),
        .in_pos_y     (s_tdata[17:9]),
        .in_delta_x   ($signed(s_tdata[27:18])),
        .in_delta_y   ($signed(s_tdata[37:28])),
        .in_query_x   ($signed(s_tdata[53:38])),
        .in_query_y   ($signed(s_tdata[69:54])),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .status       (status),
        .pairs_stored (pairs_stored)
    );

    assign m_tdata = {pairs_stored, status, dir_y, dir_x};

endmodule
